[design/tpsm_pkg.sv]
// shared constants, types and codes of the tube pair scan multiplexer
package tpsm_pkg;

    localparam int PAIR_COUNT = 3;
    localparam int NUM_TUBES  = 2 * PAIR_COUNT;
    localparam int POS_W      = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
    localparam int TUBE_W     = $clog2(NUM_TUBES);
    localparam int DIGIT_W    = 5;
    localparam int BCD_W      = 4;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [BCD_W-1:0] BLANK_CODE = 4'd15;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FLAGS = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_SCAN  = 2'd3;

    localparam logic REG_BLINK_OFF    = 1'b0;
    localparam logic REG_BLINK_PERIOD = 1'b1;

    localparam logic [15:0] BLINK_OFF_RESET    = 16'd150;
    localparam logic [15:0] BLINK_PERIOD_RESET = 16'd550;

    typedef struct packed {
        logic [15:0] blink_off_ms;
        logic [15:0] blink_period_ms;
    } cfg_t;

    typedef struct packed {
        logic [NUM_TUBES-1:0] blank;
        logic                 restart;
    } blink_upd_t;

endpackage

[design/tpsm_if.sv]
// input and result channel interfaces of the tube pair scan multiplexer
interface tpsm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [1:0]  pair_number;
    logic [7:0]  value;
    logic [2:0]  tube_index;
    logic        flash;
    logic        dot;
    logic [31:0] now_ms;
    logic [7:0]  menu_mode;

    modport source (
        output valid, op, pair_number, value, tube_index, flash, dot, now_ms, menu_mode,
        input  ready
    );
    modport sink (
        input  valid, op, pair_number, value, tube_index, flash, dot, now_ms, menu_mode,
        output ready
    );
endinterface

interface tpsm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] anode_index;
    logic [3:0] high_bcd;
    logic       high_dot;
    logic [3:0] low_bcd;
    logic       low_dot;

    modport source (
        output valid, anode_index, high_bcd, high_dot, low_bcd, low_dot,
        input  ready
    );
    modport sink (
        input  valid, anode_index, high_bcd, high_dot, low_bcd, low_dot,
        output ready
    );
endinterface

[design/tpsm_cfg.sv]
// apb configuration registers for blink timing
module tpsm_cfg
    import tpsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_BLINK_OFF:    cfg_next.blink_off_ms    = pwdata[15:0];
                REG_BLINK_PERIOD: cfg_next.blink_period_ms = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BLINK_OFF:    prdata = {16'd0, cfg_reg.blink_off_ms};
            REG_BLINK_PERIOD: prdata = {16'd0, cfg_reg.blink_period_ms};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_off_ms    <= BLINK_OFF_RESET;
            cfg_reg.blink_period_ms <= BLINK_PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/tpsm_blink.sv]
// blink blanking update of all tubes against the shared timestamp
module tpsm_blink
    import tpsm_pkg::*;
(
    input  logic [NUM_TUBES-1:0] flash_flags,
    input  logic [31:0]          now_ms,
    input  logic [31:0]          blink_stamp,
    input  cfg_t                 cfg,
    output blink_upd_t           upd
);

    logic [31:0] elapsed;
    logic        past_off;
    logic        past_period;
    logic        off_zero;
    logic        seen;

    assign elapsed     = now_ms - blink_stamp;
    assign past_off    = elapsed >= {16'd0, cfg.blink_off_ms};
    assign past_period = elapsed >= {16'd0, cfg.blink_period_ms};
    assign off_zero    = cfg.blink_off_ms == 16'd0;

    // after a restart the later flashing tubes see zero elapsed time
    always_comb
    begin
        seen      = 1'b0;
        upd.blank = '0;
        for (int i = 0; i < NUM_TUBES; i++)
        begin
            if (flash_flags[i])
            begin
                upd.blank[i] = (seen && past_off && past_period) ? off_zero : past_off;
                seen         = 1'b1;
            end
        end
        upd.restart = (|flash_flags) && past_off && past_period;
    end

endmodule

[design/tube_pair_scan_multiplexer_core.sv]
// top level of the tube pair scan multiplexer: input register, tube state, result register
//
// usage
//   in_ch carries one beat per command: load pair digits, set tube flags,
//   clear all flags, or a scan step. only a scan step yields a result beat
//   on out_ch: the anode position and bcd/dot drive of its high and low tube.
//   blink timing registers sit on the apb port (blink_off_ms at 0x0, blink_period_ms at
//   0x4); the user must write them only while idle (the block does not enforce this).
// pipeline and throughput
//   a beat is registered in the input register and processed from there; a scan
//   result is registered in the result register and leaves from there. one beat
//   per cycle is sustained unless a scan beat waits on a stalled out_ch; the tube
//   state update is a single pass of logic between the input and result registers.
// reset
//   digits, flags, blink stamp and scan position clear; blink registers take
//   150 and 550; both pipeline registers empty.
// stall
//   while out_ch is stalled a held result stays valid; non-scan beats keep
//   flowing, and a scan beat waits in the input register until the result
//   register frees, blocking new beats meanwhile.
module tube_pair_scan_multiplexer_core
    import tpsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tpsm_in_if.sink            in_ch,
    tpsm_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  pair_number;
        logic [7:0]  value;
        logic [2:0]  tube_index;
        logic        flash;
        logic        dot;
        logic [31:0] now_ms;
        logic [7:0]  menu_mode;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       anode_index;
        logic [BCD_W-1:0] high_bcd;
        logic             high_dot;
        logic [BCD_W-1:0] low_bcd;
        logic             low_dot;
    } out_beat_t;

    function automatic logic [DIGIT_W-1:0] tens_of(input logic [7:0] v);
        logic [15:0] prod;
        prod    = 16'(v) * 16'd205;
        tens_of = DIGIT_W'(prod >> 11);
    endfunction

    function automatic logic [DIGIT_W-1:0] ones_of(input logic [7:0] v,
                                                   input logic [DIGIT_W-1:0] tens);
        logic [7:0] tens_x10;
        tens_x10 = 8'(tens) * 8'd10;
        ones_of  = DIGIT_W'(4'(v - tens_x10));
    endfunction

    cfg_t       cfg;
    blink_upd_t blink_upd;

    in_beat_t s1_reg;
    in_beat_t s1_next;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    logic     s1_advance;
    logic     in_fire;

    logic [DIGIT_W-1:0]   digit_reg [NUM_TUBES];
    logic [DIGIT_W-1:0]   digit_next [NUM_TUBES];
    logic [NUM_TUBES-1:0] flash_reg;
    logic [NUM_TUBES-1:0] flash_next;
    logic [NUM_TUBES-1:0] dot_reg;
    logic [NUM_TUBES-1:0] dot_next;
    logic [NUM_TUBES-1:0] blank_reg;
    logic [NUM_TUBES-1:0] blank_next;
    logic [31:0]          stamp_reg;
    logic [31:0]          stamp_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;

    out_beat_t out_reg;
    out_beat_t out_next;
    logic      out_valid_reg;
    logic      out_valid_next;

    logic               is_scan;
    logic               edit_mode;
    logic               load_en;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
    out_beat_t          scan_beat;

    tpsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpsm_blink u_blink (
        .flash_flags (flash_reg),
        .now_ms      (s1_reg.now_ms),
        .blink_stamp (stamp_reg),
        .cfg         (cfg),
        .upd         (blink_upd)
    );

    // input side handshake
    assign is_scan    = s1_reg.op == OP_SCAN;
    assign s1_advance = s1_valid_reg && (!is_scan || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_advance;
    assign in_fire    = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_next = s1_reg;
        if (in_fire)
        begin
            s1_next.op          = in_ch.op;
            s1_next.pair_number = in_ch.pair_number;
            s1_next.value       = in_ch.value;
            s1_next.tube_index  = in_ch.tube_index;
            s1_next.flash       = in_ch.flash;
            s1_next.dot         = in_ch.dot;
            s1_next.now_ms      = in_ch.now_ms;
            s1_next.menu_mode   = in_ch.menu_mode;
        end
        s1_valid_next = in_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    end

    // digit load, shared by load beats and the edit override
    assign edit_mode = s1_reg.menu_mode != 8'd0;
    assign load_en   = (s1_reg.op == OP_LOAD) || (is_scan && edit_mode);
    assign tens      = tens_of(s1_reg.value);
    assign ones      = ones_of(s1_reg.value, tens);

    always_comb
    begin
        for (int i = 0; i < NUM_TUBES; i++)
        begin
            digit_next[i] = digit_reg[i];
            if (load_en && int'(s1_reg.pair_number) == i / 2 + 1)
            begin
                digit_next[i] = (i % 2 == 0) ? tens : ones;
            end
        end
    end

    // scan output from the current digits and last blanking
    always_comb
    begin
        scan_beat = '0;
        scan_beat.anode_index = 2'(pos_reg);
        for (int p = 0; p < PAIR_COUNT; p++)
        begin
            if (pos_reg == POS_W'(p))
            begin
                scan_beat.high_bcd = blank_reg[p] ? BLANK_CODE : digit_next[p][BCD_W-1:0];
                scan_beat.high_dot = blank_reg[p] ? 1'b0 : dot_reg[p];
                scan_beat.low_bcd  = blank_reg[p + PAIR_COUNT] ? BLANK_CODE
                                   : digit_next[p + PAIR_COUNT][BCD_W-1:0];
                scan_beat.low_dot  = blank_reg[p + PAIR_COUNT] ? 1'b0
                                   : dot_reg[p + PAIR_COUNT];
            end
        end
    end

    always_comb
    begin
        flash_next = flash_reg;
        dot_next   = dot_reg;
        blank_next = blank_reg;
        stamp_next = stamp_reg;
        pos_next   = pos_reg;
        if (s1_advance)
        begin
            case (s1_reg.op)
                OP_FLAGS:
                begin
                    for (int i = 0; i < NUM_TUBES; i++)
                    begin
                        if (s1_reg.tube_index == TUBE_W'(i))
                        begin
                            flash_next[i] = s1_reg.flash;
                            dot_next[i]   = s1_reg.dot;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    flash_next = '0;
                    dot_next   = '0;
                    blank_next = '0;
                end
                OP_SCAN:
                begin
                    if (edit_mode)
                    begin
                        blank_next = blink_upd.blank;
                        if (blink_upd.restart)
                        begin
                            stamp_next = s1_reg.now_ms;
                        end
                    end
                    pos_next = (int'(pos_reg) >= PAIR_COUNT - 1) ? '0 : pos_reg + 1'b1;
                end
                default:
                begin
                    flash_next = flash_reg;
                end
            endcase
        end
    end

    // result register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;
        if (s1_advance && is_scan)
        begin
            out_next       = scan_beat;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flash_reg     <= '0;
            dot_reg       <= '0;
            blank_reg     <= '0;
            stamp_reg     <= '0;
            pos_reg       <= '0;
            for (int i = 0; i < NUM_TUBES; i++)
            begin
                digit_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            flash_reg     <= flash_next;
            dot_reg       <= dot_next;
            blank_reg     <= blank_next;
            stamp_reg     <= stamp_next;
            pos_reg       <= pos_next;
            if (s1_advance)
            begin
                for (int i = 0; i < NUM_TUBES; i++)
                begin
                    digit_reg[i] <= digit_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.anode_index = out_reg.anode_index;
    assign out_ch.high_bcd    = out_reg.high_bcd;
    assign out_ch.high_dot    = out_reg.high_dot;
    assign out_ch.low_bcd     = out_reg.low_bcd;
    assign out_ch.low_dot     = out_reg.low_dot;

endmodule

[sim/tube_pair_scan_multiplexer_core_tb.sv]
`timescale 1ns / 100ps
// testbench of the tube pair scan multiplexer: directed and random commands
module tube_pair_scan_multiplexer_core_tb;
    import tpsm_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 130;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  pair_number;
        logic [7:0]  value;
        logic [2:0]  tube_index;
        logic        flash;
        logic        dot;
        logic [31:0] now_ms;
        logic [7:0]  menu_mode;
    } tube_cmd_t;

    typedef struct {
        logic [1:0] anode_index;
        logic [3:0] high_bcd;
        logic       high_dot;
        logic [3:0] low_bcd;
        logic       low_dot;
    } scan_beat_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tpsm_in_if  in_ch ();
    tpsm_out_if out_ch ();

    tube_pair_scan_multiplexer_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [DIGIT_W-1:0]   digit_store [NUM_TUBES];
    logic [NUM_TUBES-1:0] flash_bits;
    logic [NUM_TUBES-1:0] dot_bits;
    logic [NUM_TUBES-1:0] blank_bits;
    logic [31:0]          blink_stamp;
    int unsigned          scan_pos;
    logic [15:0]          blink_off;
    logic [15:0]          blink_period;

    scan_beat_t  expected_scans [$];
    int unsigned mismatch_count;
    bit          send_gaps;
    bit          recv_gaps;
    bit          hold_req;
    logic [31:0] sim_ms;
    int unsigned ms_step_max;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act)
        begin
            $error("%s mismatch: expected %0d actual %0d", name, exp, act);
            mismatch_count++;
        end
    endfunction

    function automatic void load_digits(logic [1:0] pair, logic [7:0] v);
        int unsigned first;
        if (pair >= 1 && pair <= PAIR_COUNT)
        begin
            first = 2 * pair - 2;
            digit_store[first]     = DIGIT_W'(v / 8'd10);
            digit_store[first + 1] = DIGIT_W'(v % 8'd10);
        end
    endfunction

    function automatic bit advance_tube_model(input tube_cmd_t c, output scan_beat_t beat);
        int unsigned pos;
        logic [31:0] elapsed;
        beat = '{default: '0};
        case (c.op)
            OP_LOAD:
            begin
                load_digits(c.pair_number, c.value);
                return 1'b0;
            end
            OP_FLAGS:
            begin
                if (c.tube_index < NUM_TUBES)
                begin
                    flash_bits[c.tube_index] = c.flash;
                    dot_bits[c.tube_index]   = c.dot;
                end
                return 1'b0;
            end
            OP_CLEAR:
            begin
                flash_bits = '0;
                dot_bits   = '0;
                blank_bits = '0;
                return 1'b0;
            end
            default:
            begin
                if (c.menu_mode != 0)
                    load_digits(c.pair_number, c.value);
                pos = scan_pos;
                beat.anode_index = 2'(pos);
                if (blank_bits[pos])
                begin
                    beat.high_bcd = BLANK_CODE;
                    beat.high_dot = 1'b0;
                end
                else
                begin
                    beat.high_bcd = digit_store[pos][BCD_W-1:0];
                    beat.high_dot = dot_bits[pos];
                end
                if (blank_bits[pos + PAIR_COUNT])
                begin
                    beat.low_bcd = BLANK_CODE;
                    beat.low_dot = 1'b0;
                end
                else
                begin
                    beat.low_bcd = digit_store[pos + PAIR_COUNT][BCD_W-1:0];
                    beat.low_dot = dot_bits[pos + PAIR_COUNT];
                end
                // blink update in tube order, shared stamp may restart midway
                if (c.menu_mode != 0)
                begin
                    for (int i = 0; i < NUM_TUBES; i++)
                    begin
                        elapsed = c.now_ms - blink_stamp;
                        if (flash_bits[i] && elapsed >= blink_off)
                        begin
                            blank_bits[i] = 1'b1;
                            if (elapsed >= blink_period)
                                blink_stamp = c.now_ms;
                        end
                        else
                            blank_bits[i] = 1'b0;
                    end
                end
                scan_pos = (pos + 1 >= PAIR_COUNT) ? 0 : pos + 1;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic tube_cmd_t make_cmd(logic [1:0] op, logic [1:0] pair, logic [7:0] v,
                                           logic [2:0] tube, logic fl, logic dt,
                                           logic [31:0] now, logic [7:0] mode);
        tube_cmd_t c;
        c.op          = op;
        c.pair_number = pair;
        c.value       = v;
        c.tube_index  = tube;
        c.flash       = fl;
        c.dot         = dt;
        c.now_ms      = now;
        c.menu_mode   = mode;
        return c;
    endfunction

    function automatic tube_cmd_t random_cmd();
        tube_cmd_t   c;
        int unsigned pick;
        c = make_cmd(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom, 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            c.op = OP_LOAD;
        else if (pick < 26)
        begin
            c.op = OP_FLAGS;
            if ($urandom_range(0, 9) != 0)
                c.tube_index = 3'($urandom_range(0, NUM_TUBES - 1));
            c.flash = ($urandom_range(0, 3) != 0);
        end
        else if (pick < 29)
            c.op = OP_CLEAR;
        else
        begin
            c.op = OP_SCAN;
            if ($urandom_range(0, 3) != 0)
                c.menu_mode = 8'($urandom_range(1, 255));
            else
                c.menu_mode = '0;
            // mostly a running clock so the blink timer walks through its states
            if ($urandom_range(0, 9) != 0)
            begin
                sim_ms += $urandom_range(0, ms_step_max);
                c.now_ms = sim_ms;
            end
        end
        return c;
    endfunction

    task automatic send_cmd(input tube_cmd_t c);
        int unsigned gap;
        scan_beat_t  beat;
        gap = send_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.op          <= c.op;
        in_ch.pair_number <= c.pair_number;
        in_ch.value       <= c.value;
        in_ch.tube_index  <= c.tube_index;
        in_ch.flash       <= c.flash;
        in_ch.dot         <= c.dot;
        in_ch.now_ms      <= c.now_ms;
        in_ch.menu_mode   <= c.menu_mode;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (advance_tube_model(c, beat))
            expected_scans.push_back(beat);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (expected_scans.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic idx, input logic [15:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= PDATA_W'(wdata);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
    endtask

    task automatic set_blink_timing(input logic [15:0] off_ms, input logic [15:0] period_ms);
        logic [PDATA_W-1:0] rd;
        apb_transfer(1'b1, REG_BLINK_OFF, off_ms, rd);
        blink_off = off_ms;
        apb_transfer(1'b1, REG_BLINK_PERIOD, period_ms, rd);
        blink_period = period_ms;
        apb_transfer(1'b0, REG_BLINK_OFF, '0, rd);
        check_field("blink_off_ms readback", off_ms, rd);
        apb_transfer(1'b0, REG_BLINK_PERIOD, '0, rd);
        check_field("blink_period_ms readback", period_ms, rd);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_directed_cases();
        send_cmd(make_cmd(OP_LOAD, 2'd0, 8'd77, 3'd0, 1'b0, 1'b0, 32'd0, 8'd0));
        send_cmd(make_cmd(OP_LOAD, 2'd1, 8'd0, 3'd0, 1'b0, 1'b0, 32'd0, 8'd0));
        send_cmd(make_cmd(OP_LOAD, 2'd2, 8'd255, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'hFF));
        send_cmd(make_cmd(OP_LOAD, 2'd3, 8'd99, 3'd0, 1'b0, 1'b0, 32'd0, 8'd0));
        repeat (4) send_cmd(make_cmd(OP_SCAN, 2'd2, 8'd0, 3'd0, 1'b0, 1'b0, 32'd0, 8'd0));
        send_cmd(make_cmd(OP_FLAGS, 2'd0, 8'd0, 3'd0, 1'b1, 1'b1, 32'd0, 8'd0));
        send_cmd(make_cmd(OP_FLAGS, 2'd0, 8'd0, 3'd3, 1'b0, 1'b1, 32'd0, 8'd0));
        send_cmd(make_cmd(OP_FLAGS, 2'd0, 8'd0, 3'd5, 1'b1, 1'b0, 32'd0, 8'd0));
        send_cmd(make_cmd(OP_FLAGS, 2'd0, 8'd0, 3'd6, 1'b1, 1'b1, 32'd0, 8'd0));
        send_cmd(make_cmd(OP_FLAGS, 2'd0, 8'd0, 3'd7, 1'b1, 1'b1, 32'd0, 8'd0));
        send_cmd(make_cmd(OP_SCAN, 2'd0, 8'd200, 3'd0, 1'b0, 1'b0, 32'd0, 8'd1));
        send_cmd(make_cmd(OP_SCAN, 2'd2, 8'd42, 3'd0, 1'b0, 1'b0, 32'd100, 8'd1));
        send_cmd(make_cmd(OP_SCAN, 2'd3, 8'd255, 3'd0, 1'b0, 1'b0, 32'd200, 8'h80));
        send_cmd(make_cmd(OP_SCAN, 2'd1, 8'd250, 3'd0, 1'b0, 1'b0, 32'd600, 8'd1));
        send_cmd(make_cmd(OP_SCAN, 2'd1, 8'd13, 3'd0, 1'b0, 1'b0, 32'hFFFF_FFFF, 8'd0));
        send_cmd(make_cmd(OP_SCAN, 2'd3, 8'd7, 3'd0, 1'b0, 1'b0, 32'hFFFF_FFFF, 8'hFF));
        send_cmd(make_cmd(OP_SCAN, 2'd2, 8'd64, 3'd0, 1'b0, 1'b0, 32'd50, 8'd1));
        send_cmd(make_cmd(OP_CLEAR, 2'd0, 8'd0, 3'd0, 1'b0, 1'b0, 32'd0, 8'd0));
        repeat (3) send_cmd(make_cmd(OP_SCAN, 2'd1, 8'd30, 3'd0, 1'b0, 1'b0, 32'd900, 8'd1));
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        tube_cmd_t c;
        send_gaps = 1'b0;
        hold_req  = 1'b1;
        repeat (30)
        begin
            c = random_cmd();
            c.op = OP_SCAN;
            send_cmd(c);
        end
        send_gaps = 1'b1;
        wait_idle();
    endtask

    task automatic test_blink_phases();
        logic [15:0] off_set    [5];
        logic [15:0] period_set [5];
        int unsigned step_set   [5];
        off_set    = '{16'd150, 16'd0, 16'd65535, 16'd10, 16'($urandom_range(0, 400))};
        period_set = '{16'd550, 16'd0, 16'd65535, 16'd20, 16'($urandom_range(0, 800))};
        step_set   = '{120, 50, 40000, 15, $urandom_range(1, 300)};
        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            set_blink_timing(off_set[p], period_set[p]);
            ms_step_max = step_set[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 20 == 0)
                begin
                    send_gaps = ($urandom_range(0, 2) != 0);
                    recv_gaps = ($urandom_range(0, 2) != 0);
                end
                send_cmd(random_cmd());
            end
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    initial
    begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = recv_gaps ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready) && !hold_req);
        end
    end

    always @(posedge clk)
    begin : check_scans
        scan_beat_t exp;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_scans.size() == 0)
            begin
                $error("scan beat with none expected: anode_index %0d", out_ch.anode_index);
                mismatch_count++;
            end
            else
            begin
                exp = expected_scans.pop_front();
                check_field("anode_index", exp.anode_index, out_ch.anode_index);
                check_field("high_bcd", exp.high_bcd, out_ch.high_bcd);
                check_field("high_dot", exp.high_dot, out_ch.high_dot);
                check_field("low_bcd", exp.low_bcd, out_ch.low_bcd);
                check_field("low_dot", exp.low_dot, out_ch.low_dot);
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_LOAD;
        in_ch.pair_number = '0;
        in_ch.value       = '0;
        in_ch.tube_index  = '0;
        in_ch.flash       = 1'b0;
        in_ch.dot         = 1'b0;
        in_ch.now_ms      = '0;
        in_ch.menu_mode   = '0;
        for (int i = 0; i < NUM_TUBES; i++)
            digit_store[i] = '0;
        flash_bits     = '0;
        dot_bits       = '0;
        blank_bits     = '0;
        blink_stamp    = '0;
        scan_pos       = 0;
        blink_off      = BLINK_OFF_RESET;
        blink_period   = BLINK_PERIOD_RESET;
        mismatch_count = 0;
        send_gaps      = 1'b1;
        recv_gaps      = 1'b1;
        hold_req       = 1'b0;
        sim_ms         = '0;
        ms_step_max    = 120;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_blink_phases();
        wait_idle();

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
